@@ hw/rtl/rkqd_pkg.sv @@
// ---------------------------------------------------------------------------
// Rotary knob quadrature decoder package
// Shared types, register indexes and the transition decode table.
// ---------------------------------------------------------------------------
`default_nettype none

package rkqd_pkg;

    // Field and register widths.
    localparam int TICK_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Reset value of the button lockout, in ticks.
    localparam logic [CFG_W-1:0] BUTTON_LOCKOUT_RESET = 16'd50;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE_TICKS  = 2'd0,
        REG_INVERT_DIR      = 2'd1,
        REG_BUTTON_LOCKOUT  = 2'd2
    } t_cfg_reg;

    // Event kind carried by an input word.
    typedef enum logic {
        FUNC_ENCODER = 1'b0,
        FUNC_BUTTON  = 1'b1
    } t_func;

    // Result word codes.
    typedef enum logic [1:0] {
        CODE_CW     = 2'd0,
        CODE_CCW    = 2'd1,
        CODE_BUTTON = 2'd2
    } t_event_code;

    // Direction decoded from one pin transition.
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } t_dir;

    // Outcome of one event, handed from the decision logic to the top level.
    typedef struct packed {
        logic        enc_accept;
        logic        btn_accept;
        logic        has_result;
        t_event_code code;
    } t_decision;

    // Transition index is previous state in the upper two bits, current below.
    function automatic t_dir transition_dir(input logic [3:0] idx);
        t_dir d;
        unique case (idx)
            4'h1, 4'h7, 4'h8, 4'hE: d = DIR_CW;
            4'h2, 4'hB, 4'hD, 4'h4: d = DIR_CCW;
            default:                d = DIR_NONE;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rotary_knob_quadrature_decoder_top.sv @@
// ---------------------------------------------------------------------------
// Rotary knob quadrature decoder, top level
// Time-stamped encoder and button events in, step and press words out.
// ---------------------------------------------------------------------------
// Each input word is registered, decided from the input register and, when it
// produces a result, placed in an output register. One word is taken every
// cycle while the input is not stalled. The rate is set by the single
// decision stage, which reads and updates the stored pin state and timestamps
// in the same cycle. Encoder words arriving inside the debounce window and
// button words inside the lockout are dropped without changing any state. The
// stored pin state resets to 00 and both timestamps to zero. Configuration may
// be written only while no word is in flight.
`default_nettype none

module rotary_knob_quadrature_decoder_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration write port.
    input  wire logic                         i_cfg_we,
    input  wire logic [rkqd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [rkqd_pkg::CFG_W-1:0]     i_cfg_data,
    // Input channel.
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_func,
    input  wire logic [rkqd_pkg::TICK_W-1:0]    i_now_ticks,
    input  wire logic                         i_pin_a,
    input  wire logic                         i_pin_b,
    // Output channel.
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [1:0]                        o_event_code
);
    import rkqd_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0]  r_debounce_ticks;
    logic              r_invert_dir;
    logic [CFG_W-1:0]  r_button_lockout;

    // Input register.
    logic              r_in_valid;
    logic              r_func;
    logic [TICK_W-1:0] r_now_ticks;
    logic [1:0]        r_pins;

    // Decoder state.
    logic [1:0]        r_prev_pins;
    logic [TICK_W-1:0] r_last_enc_time;
    logic [TICK_W-1:0] r_last_btn_time;

    // Output register.
    logic              r_out_valid;
    t_event_code       r_event_code;

    t_decision         decision;
    logic              out_free;
    logic              advance;
    logic              in_take;

    // Configuration writes; an index past the last register is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= '0;
            r_invert_dir     <= 1'b0;
            r_button_lockout <= BUTTON_LOCKOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg_data;
                REG_INVERT_DIR:     r_invert_dir     <= i_cfg_data[0];
                REG_BUTTON_LOCKOUT: r_button_lockout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Decision logic for the word held in the input register.
    rkqd_decide u_decide (
        .i_func           (r_func),
        .i_now_ticks      (r_now_ticks),
        .i_pins           (r_pins),
        .i_prev_pins      (r_prev_pins),
        .i_last_enc_time  (r_last_enc_time),
        .i_last_btn_time  (r_last_btn_time),
        .i_debounce_ticks (r_debounce_ticks),
        .i_invert_dir     (r_invert_dir),
        .i_button_lockout (r_button_lockout),
        .o_decision       (decision)
    );

    // A word without a result may retire even while the output is blocked.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (out_free || !decision.has_result);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func      <= i_func;
            r_now_ticks <= i_now_ticks;
            r_pins      <= {i_pin_b, i_pin_a};
        end
    end

    // Stored pin state and timestamps, updated only by accepted events.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pins     <= 2'b00;
            r_last_enc_time <= '0;
            r_last_btn_time <= '0;
        end else if (advance) begin
            if (decision.enc_accept) begin
                r_prev_pins     <= r_pins;
                r_last_enc_time <= r_now_ticks;
            end
            if (decision.btn_accept) begin
                r_last_btn_time <= r_now_ticks;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && decision.has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && decision.has_result) begin
            r_event_code <= decision.code;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_code = r_event_code;

endmodule

`default_nettype wire

@@ hw/rtl/rkqd_decide.sv @@
// ---------------------------------------------------------------------------
// Rotary knob event decision
// Applies the debounce and lockout windows to one event and decodes the
// encoder transition into a result code.
// ---------------------------------------------------------------------------
`default_nettype none

module rkqd_decide (
    input  wire logic                      i_func,
    input  wire logic [rkqd_pkg::TICK_W-1:0] i_now_ticks,
    input  wire logic [1:0]                i_pins,
    input  wire logic [1:0]                i_prev_pins,
    input  wire logic [rkqd_pkg::TICK_W-1:0] i_last_enc_time,
    input  wire logic [rkqd_pkg::TICK_W-1:0] i_last_btn_time,
    input  wire logic [rkqd_pkg::CFG_W-1:0]  i_debounce_ticks,
    input  wire logic                      i_invert_dir,
    input  wire logic [rkqd_pkg::CFG_W-1:0]  i_button_lockout,
    output rkqd_pkg::t_decision            o_decision
);
    import rkqd_pkg::*;

    logic [TICK_W-1:0] enc_elapsed;
    logic [TICK_W-1:0] btn_elapsed;
    logic              enc_open;
    logic              btn_open;
    t_dir              dir;

    // Elapsed time wraps modulo 2^32, so a plain subtraction is enough.
    assign enc_elapsed = i_now_ticks - i_last_enc_time;
    assign btn_elapsed = i_now_ticks - i_last_btn_time;
    assign enc_open    = enc_elapsed >= {{(TICK_W-CFG_W){1'b0}}, i_debounce_ticks};
    assign btn_open    = btn_elapsed >= {{(TICK_W-CFG_W){1'b0}}, i_button_lockout};

    assign dir = transition_dir({i_prev_pins, i_pins});

    // Combine the window checks with the decoded direction.
    always_comb begin
        o_decision = '0;
        o_decision.code = CODE_CW;
        if (t_func'(i_func) == FUNC_BUTTON) begin
            o_decision.btn_accept = btn_open;
            o_decision.has_result = btn_open;
            o_decision.code       = CODE_BUTTON;
        end else begin
            o_decision.enc_accept = enc_open;
            o_decision.has_result = enc_open && (dir != DIR_NONE);
            if ((dir == DIR_CW) != i_invert_dir) begin
                o_decision.code = CODE_CW;
            end else begin
                o_decision.code = CODE_CCW;
            end
        end
    end

endmodule

`default_nettype wire
